@@ hw/rtl/rmt_pkg.sv @@
// ============================================================================
// rmt_pkg
// Shared types and constants for the range minimum tree: field widths,
// controller states and the command/status groups between control and data.
// ============================================================================
package rmt_pkg;

    localparam int CAPACITY_DEF    = 1024;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int POS_W  = 10;
    localparam int REND_W = 11;
    localparam int VAL_W  = 32;
    localparam int MIN_W  = 32;

    // s_axis_tdata layout, lowest bit up
    localparam int IN_DATA_W  = 56;
    localparam int POS_LSB    = 0;
    localparam int REND_LSB   = POS_LSB + POS_W;
    localparam int VAL_LSB    = REND_LSB + REND_W;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_W_LEAF,
        S_W_READ,
        S_W_UP,
        S_Q_STEP,
        S_OUT
    } t_state;

    typedef struct packed {
        logic clear_step;
        logic load;
        logic w_leaf;
        logic w_read;
        logic w_up;
        logic q_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic in_query;
        logic in_write_ok;
        logic at_root;
        logic range_done;
        logic out_free;
    } t_status;

endpackage

@@ hw/rtl/range_minimum_tree_top.sv @@
// ============================================================================
// range_minimum_tree_top
// Segment tree answering range minimum queries over signed leaf values.
// ============================================================================
// After reset the block runs a clearing pass over all 2*CAPACITY nodes
// (one node a cycle) with s_axis_tready low; every leaf then reads as the
// largest signed value. One item is worked at a time. In a leaf write the
// leaf is stored, then each level reads the sibling and writes the parent
// on the single write port. In a query the left and right edges are read
// in the same cycle on the two read ports, one level per cycle, and the
// result lands in an output register. A write outside the store is
// dropped at once. The next item is taken while a result still waits on
// the master side.
module range_minimum_tree_top #(
    parameter int CAPACITY    = rmt_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = rmt_pkg::VALUE_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [9:0] position, [20:10] right_end, [52:21] new_value, [55:53] zero
    input  logic [rmt_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [0] command
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [31:0] minimum
    output logic [rmt_pkg::MIN_W-1:0]         m_axis_tdata
);

    import rmt_pkg::*;

    t_cmd                    cmd;
    t_status                 status;
    logic signed [MIN_W-1:0] minimum;

    rmt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_ready (s_axis_tready)
    );

    rmt_datapath #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_command   (s_axis_tuser),
        .i_position  (s_axis_tdata[POS_LSB +: POS_W]),
        .i_right_end (s_axis_tdata[REND_LSB +: REND_W]),
        .i_new_value ($signed(s_axis_tdata[VAL_LSB +: VAL_W])),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_minimum   (minimum)
    );

    assign m_axis_tdata = $unsigned(minimum);

endmodule

@@ hw/rtl/rmt_ram.sv @@
// ============================================================================
// rmt_ram
// Generic RAM: one write port, two read ports with registered read data.
// ============================================================================
module rmt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

@@ hw/rtl/rmt_ctrl.sv @@
// ============================================================================
// rmt_ctrl
// Controller: sequences the clearing pass, leaf writes with the walk up to
// the root, range queries level by level, and the result hand-off.
// ============================================================================
module rmt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  rmt_pkg::t_status i_status,
    output rmt_pkg::t_cmd    o_cmd,
    output logic             o_in_ready
);

    import rmt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_status.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_status.in_query) begin
                        n_state = S_Q_STEP;
                    end else if (i_status.in_write_ok) begin
                        n_state = S_W_LEAF;
                    end
                end
            end
            S_W_LEAF: n_state = S_W_READ;
            S_W_READ: begin
                n_state = i_status.at_root ? S_IDLE : S_W_UP;
            end
            S_W_UP:   n_state = S_W_READ;
            S_Q_STEP: begin
                if (i_status.range_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR:  o_cmd.clear_step = 1'b1;
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_W_LEAF: o_cmd.w_leaf = 1'b1;
            S_W_READ: o_cmd.w_read = 1'b1;
            S_W_UP:   o_cmd.w_up   = 1'b1;
            S_Q_STEP: o_cmd.q_step = 1'b1;
            S_OUT:    o_cmd.out_load = i_status.out_free;
            default:  o_cmd = '0;
        endcase
    end

endmodule

@@ hw/rtl/rmt_datapath.sv @@
// ============================================================================
// rmt_datapath
// Datapath: node store, walk indices, running minimum and result register.
// Values are held in offset form (sign bit flipped) so unsigned compares
// give signed order.
// ============================================================================
module rmt_datapath #(
    parameter int CAPACITY    = rmt_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = rmt_pkg::VALUE_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  rmt_pkg::t_cmd                      i_cmd,
    output rmt_pkg::t_status                   o_status,
    input  logic                               i_command,
    input  logic [rmt_pkg::POS_W-1:0]          i_position,
    input  logic [rmt_pkg::REND_W-1:0]         i_right_end,
    input  logic signed [rmt_pkg::VAL_W-1:0]   i_new_value,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic signed [rmt_pkg::MIN_W-1:0]   o_minimum
);

    import rmt_pkg::*;

    localparam int DEPTH = 2 * CAPACITY;
    localparam int NW    = $clog2(DEPTH);
    localparam int CW    = (NW + 1 > REND_W) ? NW + 1 : REND_W;
    localparam logic [VALUE_WIDTH-1:0] VMAX  = {VALUE_WIDTH{1'b1}};
    localparam logic [VALUE_WIDTH-1:0] VSIGN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);
    localparam logic [NW-1:0] LAST_ENTRY = NW'(DEPTH - 1);
    localparam logic [NW-1:0] ROOT = NW'(1);

    logic [NW-1:0]          r_clr_cnt;
    logic [NW-1:0]          r_node;
    logic [VALUE_WIDTH-1:0] r_cur;
    logic [CW-1:0]          r_lo;
    logic [CW-1:0]          r_hi;
    logic                   r_take_a;
    logic                   r_take_b;
    logic [VALUE_WIDTH-1:0] r_best;
    logic                   r_out_valid;
    logic [MIN_W-1:0]       r_out_data;

    logic [CW-1:0]          pos_ext;
    logic [CW-1:0]          rend_ext;
    logic [CW-1:0]          rend_clip;
    logic [CW-1:0]          leaf;
    logic [CW-1:0]          hi_m1;
    logic [VALUE_WIDTH-1:0] key;
    logic                   range_done;

    logic                   ram_we;
    logic [NW-1:0]          ram_waddr;
    logic [VALUE_WIDTH-1:0] ram_wdata;
    logic [NW-1:0]          ram_raddr_a;
    logic [NW-1:0]          ram_raddr_b;
    logic [VALUE_WIDTH-1:0] rdata_a;
    logic [VALUE_WIDTH-1:0] rdata_b;

    logic [VALUE_WIDTH-1:0] up_min;
    logic [VALUE_WIDTH-1:0] val_a;
    logic [VALUE_WIDTH-1:0] val_b;
    logic [VALUE_WIDTH-1:0] acc_1;
    logic [VALUE_WIDTH-1:0] acc_2;

    assign pos_ext   = CW'(i_position);
    assign rend_ext  = CW'(i_right_end);
    assign rend_clip = (rend_ext > CAP) ? CAP : rend_ext;
    assign leaf      = pos_ext + CAP;
    assign key       = VALUE_WIDTH'($unsigned(i_new_value)) ^ VSIGN;
    assign hi_m1     = r_hi - CW'(1);
    assign range_done = !(r_lo < r_hi);

    assign up_min = (rdata_a < r_cur) ? rdata_a : r_cur;
    assign val_a  = r_take_a ? rdata_a : VMAX;
    assign val_b  = r_take_b ? rdata_b : VMAX;
    assign acc_1  = (val_a < r_best) ? val_a : r_best;
    assign acc_2  = (val_b < acc_1) ? val_b : acc_1;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_node;
        ram_wdata = r_cur;
        if (i_cmd.clear_step) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_cnt;
            ram_wdata = VMAX;
        end else if (i_cmd.w_leaf) begin
            ram_we    = 1'b1;
        end else if (i_cmd.w_up) begin
            ram_we    = 1'b1;
            ram_waddr = r_node >> 1;
            ram_wdata = up_min;
        end
    end

    // port A: sibling during write walk, left edge during query
    assign ram_raddr_a = i_cmd.w_read ? (r_node ^ NW'(1)) : r_lo[NW-1:0];
    assign ram_raddr_b = hi_m1[NW-1:0];

    rmt_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt   <= '0;
            r_take_a    <= 1'b0;
            r_take_b    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_step) r_clr_cnt <= r_clr_cnt + NW'(1);
            if (i_cmd.load) begin
                r_take_a <= 1'b0;
                r_take_b <= 1'b0;
            end else if (i_cmd.q_step) begin
                r_take_a <= !range_done && r_lo[0];
                r_take_b <= !range_done && r_hi[0];
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_node <= leaf[NW-1:0];
            r_cur  <= key;
            r_lo   <= leaf;
            r_hi   <= rend_clip + CAP;
            r_best <= VMAX;
        end
        if (i_cmd.w_up) begin
            r_node <= r_node >> 1;
            r_cur  <= up_min;
        end
        if (i_cmd.q_step) begin
            // fold in the reads issued last cycle, then climb one level
            r_best <= acc_2;
            if (!range_done) begin
                r_lo <= (r_lo + CW'(r_lo[0])) >> 1;
                r_hi <= (r_hi - CW'(r_hi[0])) >> 1;
            end
        end
        if (i_cmd.out_load) begin
            r_out_data <= MIN_W'(r_best ^ VSIGN);
        end
    end

    assign o_status.clear_last  = (r_clr_cnt == LAST_ENTRY);
    assign o_status.in_query    = (i_command == CMD_QUERY);
    assign o_status.in_write_ok = (pos_ext < CAP);
    assign o_status.at_root     = (r_node == ROOT);
    assign o_status.range_done  = range_done;
    assign o_status.out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_minimum   = $signed(r_out_data);

endmodule
